>>> design/ptw_pkg.sv
package ptw_pkg;

  localparam int ENTRY_W = 64;
  localparam int VA_W    = 48;
  localparam int PA_W    = 52;
  localparam int PFN_W   = 40;
  localparam int NF_W    = 13;
  localparam int SLOT_W  = 9;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [PFN_W-1:0]   pfn_t;
  typedef logic [1:0]         status_t;
  typedef logic [1:0]         func_t;

  localparam func_t FUNC_LOOKUP = 2'd0;
  localparam func_t FUNC_MAP    = 2'd1;
  localparam func_t FUNC_UNMAP  = 2'd2;

  localparam status_t STAT_OK   = 2'd0;
  localparam status_t STAT_MISS = 2'd1;
  localparam status_t STAT_FULL = 2'd2;
  localparam status_t STAT_OUT  = 2'd3;

endpackage

>>> design/ptw_ram.sv
module ptw_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> design/four_level_page_table_walker_core.sv
// channel  direction  handshake                  payload
// in       slave      in_tvalid / in_tready      tuser: func; tdata: virt, phys, flags
// out      master     out_tvalid / out_tready    tuser: status; tdata: entry value, addr
// cfg      slave      cfg_valid / cfg_ready      cfg_data: table base
//
// One item at a time through the single port of the entry memory: three levels
// of read, evaluate and table check, then a leaf read and update, plus accept
// and result hand-off; a miss, a full table set or a failed table check ends the walk early.
// After reset a clearing pass writes every entry with in_tready low;
// cfg writes are taken at any time. A result waits in the output register while the
// next item is accepted; that item finishes only once the register is free.
module four_level_page_table_walker_core #(
  parameter int TABLES = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // func
  input  logic [167:0] in_tdata,   // virt_addr[47:0], phys_addr[99:48], flags[163:100]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // status
  output logic [119:0] out_tdata,  // entry_value[63:0], entry_addr[115:64]
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [51:0]  cfg_data
);
  import ptw_pkg::*;

  localparam int TW    = $clog2(TABLES);
  localparam int AW    = TW + SLOT_W;
  localparam int DEPTH = TABLES * 512;
  localparam logic [AW-1:0]    LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [NF_W-1:0]  TABLES_NF = NF_W'(TABLES);
  localparam logic [PFN_W-1:0] TABLES_PF = PFN_W'(TABLES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_LEAF = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic            clr_r, clr_nxt;
  logic [AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [NF_W-1:0] next_free_r, next_free_nxt;
  pfn_t            base_r;

  func_t           func_r;
  logic [VA_W-1:0] va_r;
  logic [PA_W-1:0] pa_r;
  entry_t          fl_r;
  logic [1:0]      lvl_r, lvl_nxt;
  logic [TW-1:0]   tbl_r, tbl_nxt;
  entry_t          ent_r, ent_nxt;

  status_t         res_st_r, res_st_nxt;
  entry_t          res_val_r, res_val_nxt;
  logic [PA_W-1:0] res_addr_r, res_addr_nxt;

  logic            out_valid_r;
  status_t         out_st_r;
  entry_t          out_val_r;
  logic [PA_W-1:0] out_addr_r;

  logic            mem_we;
  logic [AW-1:0]   mem_addr;
  logic [64:0]     mem_wdata, mem_rdata;

  logic [SLOT_W-1:0] idx;
  logic            alloc_cur, alloc_new, tag_cur;
  entry_t          eff;
  pfn_t            new_pfn, leaf_pfn;
  logic [PFN_W:0]  diff;
  logic [NF_W-1:0] tbl_nf;
  logic            accept, out_free;

  ptw_ram #(.WIDTH(65), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .addr (mem_addr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  assign in_tready  = (state_r == S_IDLE) && !clr_r;
  assign accept     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {4'b0, out_addr_r, out_val_r};
  assign out_free   = !out_valid_r || out_tready;

  always_comb begin
    unique case (lvl_r)
      2'd0:    idx = va_r[47:39];
      2'd1:    idx = va_r[38:30];
      2'd2:    idx = va_r[29:21];
      default: idx = va_r[20:12];
    endcase
  end

  // table t is live once allocated: 1 <= t < next_free
  assign tbl_nf    = NF_W'(tbl_r);
  assign alloc_cur = (tbl_r != '0) && (tbl_nf < next_free_r);
  assign alloc_new = (tbl_r != '0) && (tbl_nf < next_free_nxt);
  assign tag_cur   = mem_rdata[64];
  assign eff       = (tag_cur == alloc_cur) ? mem_rdata[63:0] : '0;
  assign new_pfn   = base_r + PFN_W'(next_free_r);
  assign leaf_pfn  = base_r + PFN_W'(tbl_r);
  assign diff      = {1'b0, ent_r[51:12]} - {1'b0, base_r};

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    clr_cnt_nxt   = clr_cnt_r;
    next_free_nxt = next_free_r;
    lvl_nxt       = lvl_r;
    tbl_nxt       = tbl_r;
    ent_nxt       = ent_r;
    res_st_nxt    = res_st_r;
    res_val_nxt   = res_val_r;
    res_addr_nxt  = res_addr_r;
    mem_we        = 1'b0;
    mem_addr      = {tbl_r, idx};
    mem_wdata     = '0;

    if (clr_r) begin
      mem_we      = 1'b1;
      mem_addr    = clr_cnt_r;
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == LAST_ADDR) begin
        clr_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          lvl_nxt      = 2'd0;
          tbl_nxt      = '0;
          res_st_nxt   = STAT_OK;
          res_val_nxt  = '0;
          res_addr_nxt = '0;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        state_nxt = (lvl_r == 2'd3) ? S_LEAF : S_EVAL;
      end
      S_EVAL: begin
        if (eff[0]) begin
          ent_nxt   = eff;
          state_nxt = S_CHK;
        end else if (func_r != FUNC_MAP) begin
          res_st_nxt = STAT_MISS;
          state_nxt  = S_OUT;
        end else if (next_free_r >= TABLES_NF) begin
          res_st_nxt = STAT_FULL;
          state_nxt  = S_OUT;
        end else begin
          next_free_nxt = next_free_r + 1'b1;
          ent_nxt       = {fl_r[63:12] | {12'b0, new_pfn}, 11'b0, 1'b1};
          mem_we        = 1'b1;
          mem_wdata     = {alloc_new, fl_r[63:12] | {12'b0, new_pfn}, 11'b0, 1'b1};
          state_nxt     = S_CHK;
        end
      end
      S_CHK: begin
        if (diff[PFN_W] || (diff[PFN_W-1:0] >= TABLES_PF)) begin
          res_st_nxt = STAT_OUT;
          state_nxt  = S_OUT;
        end else begin
          tbl_nxt   = diff[TW-1:0];
          lvl_nxt   = lvl_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_LEAF: begin
        state_nxt = S_OUT;
        if (func_r == FUNC_MAP) begin
          mem_we       = 1'b1;
          mem_wdata    = {alloc_cur, fl_r[63:52], pa_r[51:12], fl_r[11:1], 1'b1};
          res_val_nxt  = {fl_r[63:52], pa_r[51:12], fl_r[11:1], 1'b1};
          res_addr_nxt = {leaf_pfn, va_r[20:12], 3'b000};
        end else if (!eff[0]) begin
          res_st_nxt = STAT_MISS;
        end else begin
          res_addr_nxt = {leaf_pfn, va_r[20:12], 3'b000};
          if (func_r == FUNC_UNMAP) begin
            mem_we    = 1'b1;
            mem_wdata = {alloc_cur, 64'b0};
          end else begin
            res_val_nxt = eff;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      next_free_r <= NF_W'(1);
      base_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      next_free_r <= next_free_nxt;
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data[51:12];
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r <= in_tuser;
      va_r   <= in_tdata[47:0];
      pa_r   <= in_tdata[99:48];
      fl_r   <= in_tdata[163:100];
    end
    lvl_r      <= lvl_nxt;
    tbl_r      <= tbl_nxt;
    ent_r      <= ent_nxt;
    res_st_r   <= res_st_nxt;
    res_val_r  <= res_val_nxt;
    res_addr_r <= res_addr_nxt;
    if (state_r == S_OUT && out_free) begin
      out_st_r   <= res_st_r;
      out_val_r  <= (res_st_r == STAT_OK) ? res_val_r : '0;
      out_addr_r <= (res_st_r == STAT_OK) ? res_addr_r : '0;
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ptw_pkg::*;

  localparam int TBL = 64;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam entry_t ADDR_MASK = 64'h000F_FFFF_FFFF_F000;
  localparam entry_t PHYS_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [51:0] BASE_MAX = 52'hF_FFFF_FFFF_F000;
  localparam func_t FUNC_RSVD = 2'd3;

  typedef struct {
    func_t       func;
    logic [47:0] va;
    logic [51:0] pa;
    entry_t      flags;
  } page_op_t;

  typedef struct {
    status_t     status;
    entry_t      value;
    logic [51:0] addr;
  } walk_res_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [1:0]   in_tuser;   // func
  logic [167:0] in_tdata;   // virt_addr[47:0], phys_addr[99:48], flags[163:100]
  logic         out_tvalid;
  logic         out_tready;
  logic [1:0]   out_tuser;  // status
  logic [119:0] out_tdata;  // entry_value[63:0], entry_addr[115:64]
  logic         cfg_valid;
  logic         cfg_ready;
  logic [51:0]  cfg_data;

  four_level_page_table_walker_core #(
    .TABLES(TBL)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  entry_t      pte_store [TBL*512];
  int unsigned next_table;
  entry_t      base_q;

  page_op_t    op_queue[$];
  walk_res_t   walk_results[$];
  page_op_t    cur_op;
  int          send_idle = 0;
  int          recv_idle = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  function automatic entry_t tbl_phys(int unsigned n);
    return (base_q + (64'(n) << 12)) & PHYS_MASK;
  endfunction

  function automatic bit table_of(entry_t e, output int unsigned n);
    entry_t a;
    entry_t idx;
    a = e & ADDR_MASK;
    n = 0;
    if (a < base_q) return 1'b0;
    idx = (a - base_q) >> 12;
    if (idx >= TBL) return 1'b0;
    n = int'(idx);
    return 1'b1;
  endfunction

  function automatic int unsigned level_idx(logic [47:0] va, int unsigned lv);
    return int'((va >> (39 - 9 * lv)) & 48'h1FF);
  endfunction

  // walks the local table store, allocating and writing as the block does
  function automatic walk_res_t run_page_op(page_op_t op);
    walk_res_t   r;
    int unsigned t;
    int unsigned lv;
    int unsigned n;
    int unsigned i;
    int unsigned pos;
    int unsigned slot;
    entry_t      e;
    r.status = STAT_OK;
    r.value = '0;
    r.addr = '0;
    t = 0;
    slot = 32'(op.va[20:12]);
    if (op.func == FUNC_MAP) begin
      for (lv = 0; lv < 3 && r.status == STAT_OK; lv++) begin
        pos = t * 512 + level_idx(op.va, lv);
        if (!pte_store[pos][0]) begin
          if (next_table >= TBL) begin
            r.status = STAT_FULL;
          end else begin
            n = next_table;
            next_table = (n + 1) & 13'h1FFF;
            for (i = 0; i < 512; i++) pte_store[n * 512 + i] = '0;
            pte_store[pos] = (tbl_phys(n) & ADDR_MASK) | (op.flags & ~64'hFFF) | 64'd1;
          end
        end
        if (r.status == STAT_OK && !table_of(pte_store[pos], t)) r.status = STAT_OUT;
      end
      if (r.status == STAT_OK) begin
        r.value = ({12'b0, op.pa} & ADDR_MASK) | (op.flags & ~ADDR_MASK) | 64'd1;
        pte_store[t * 512 + slot] = r.value;
        r.addr = 52'((tbl_phys(t) + slot * 8) & PHYS_MASK);
      end
    end else begin
      for (lv = 0; lv < 3 && r.status == STAT_OK; lv++) begin
        e = pte_store[t * 512 + level_idx(op.va, lv)];
        if (!e[0]) r.status = STAT_MISS;
        else if (!table_of(e, t)) r.status = STAT_OUT;
      end
      if (r.status == STAT_OK) begin
        e = pte_store[t * 512 + slot];
        if (!e[0]) begin
          r.status = STAT_MISS;
        end else begin
          r.addr = 52'((tbl_phys(t) + slot * 8) & PHYS_MASK);
          if (op.func == FUNC_UNMAP) pte_store[t * 512 + slot] = '0;
          else r.value = e;
        end
      end
    end
    return r;
  endfunction

  function automatic entry_t rand64();
    return {$urandom, $urandom};
  endfunction

  // index pool kept small so that walks share tables
  function automatic logic [8:0] pick_idx();
    case ($urandom_range(0, 3))
      0: return 9'd0;
      1: return 9'd5;
      2: return 9'h1FE;
      default: return 9'h1FF;
    endcase
  endfunction

  function automatic void push_op(func_t f, logic [47:0] va, logic [51:0] pa, entry_t fl);
    op_queue.push_back('{f, va, pa, fl});
  endfunction

  task automatic set_base(logic [51:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    base_q = {12'b0, v[51:12], 12'b0};
  endtask

  // checked between edges so that queue and handshake updates have settled
  task automatic drain();
    do @(negedge clk);
    while (op_queue.size() > 0 || in_tvalid || walk_results.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  // mostly map / lookup runs on one address, half of them followed by unmap / lookup, some loose items
  task automatic load_random(int count);
    int          made;
    logic [47:0] va;
    entry_t      fl;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        va = 48'(rand64());
      end else begin
        va = {pick_idx(), pick_idx(), pick_idx(),
              ($urandom_range(0, 3) == 0) ? 9'($urandom) : pick_idx(), 12'($urandom)};
      end
      if ($urandom_range(0, 99) < 70) begin
        fl = ($urandom_range(0, 4) == 0) ? rand64() : (rand64() & ~ADDR_MASK);
        push_op(FUNC_MAP, va, 52'(rand64()), fl);
        push_op(FUNC_LOOKUP, va, 52'(rand64()), rand64());
        made += 2;
        if ($urandom_range(0, 1) == 1) begin
          push_op(FUNC_UNMAP, va, 52'(rand64()), rand64());
          push_op(($urandom_range(0, 3) == 0) ? FUNC_RSVD : FUNC_LOOKUP, va,
                  52'(rand64()), rand64());
          made += 2;
        end
      end else begin
        push_op(func_t'($urandom_range(0, 3)), va, 52'(rand64()), rand64());
        made++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) walk_results.push_back(run_page_op(cur_op));
      if (!in_tvalid || in_tready) begin
        if (op_queue.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_op = op_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= cur_op.func;
          in_tdata <= {4'b0, cur_op.flags, cur_op.pa, cur_op.va};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_check
    walk_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle);
      if (out_tvalid && out_tready) begin
        if (walk_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected item: status %0d value %h addr %h",
                     out_tuser, out_tdata[63:0], out_tdata[115:64]);
        end else begin
          want = walk_results.pop_front();
          if (out_tuser !== want.status || out_tdata[63:0] !== want.value ||
              out_tdata[115:64] !== want.addr) begin
            mismatches++;
            if (mismatches <= 10)
              $display("item mismatch (exp/got): status %0d/%0d value %h/%h addr %h/%h",
                       want.status, out_tuser, want.value, out_tdata[63:0],
                       want.addr, out_tdata[115:64]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : stimulus
    int          ph;
    int          i;
    logic [51:0] bases [6];
    int          counts [6];
    clk = 1'b0;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= '0;
    in_tdata <= '0;
    out_tready <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    for (i = 0; i < TBL * 512; i++) pte_store[i] = '0;
    next_table = 1;
    base_q = '0;

    bases[0] = 52'h0;
    bases[1] = 52'h0_0000_0000_1ABC;
    bases[2] = BASE_MAX;
    bases[3] = 52'h0;
    bases[4] = 52'(($urandom_range(1, 3) << 12) | $urandom_range(0, 4095));
    bases[5] = 52'h0;
    counts = '{250, 60, 40, 250, 60, 270};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle = 33;
    recv_idle = 67;

    // low bits of the base are ignored
    set_base(52'h0_0000_0000_0ABC);
    push_op(FUNC_LOOKUP, '0, '0, '0);
    push_op(FUNC_UNMAP, '0, '0, '0);
    push_op(FUNC_MAP, '0, '1, '0);
    push_op(FUNC_LOOKUP, '0, '0, '1);
    push_op(FUNC_RSVD, '0, '1, '1);
    push_op(FUNC_MAP, '1, '0, 64'hFFF0_0000_0000_0FFE);
    push_op(FUNC_LOOKUP, '1, '0, '0);
    push_op(FUNC_UNMAP, '1, '0, '0);
    push_op(FUNC_LOOKUP, '1, '0, '0);
    push_op(FUNC_UNMAP, '1, '0, '0);
    push_op(FUNC_MAP, 48'h0000_0000_1000, 52'h1_2345_6789_A000, '1);
    push_op(FUNC_LOOKUP, 48'h0000_0000_1000, '0, '0);
    // all-ones flags corrupt the new table pointer
    push_op(FUNC_MAP, 48'h0080_0000_0000, '1, '1);
    push_op(FUNC_LOOKUP, 48'h0080_0000_0000, '0, '0);
    push_op(FUNC_UNMAP, 48'h0080_0000_0000, '0, '0);
    // pointer lands past the last table
    push_op(FUNC_MAP, 48'h0100_0000_0000, 52'h0_0000_0000_5000, 64'h0000_0000_0004_0000);
    push_op(FUNC_LOOKUP, 48'h0100_0000_0000, '0, '0);
    drain();

    // top base: old tables fall below it, new ones wrap around
    set_base(BASE_MAX | 52'hFFF);
    push_op(FUNC_LOOKUP, '0, '0, '0);
    push_op(FUNC_MAP, 48'h0180_0000_0000, '1, '0);
    push_op(FUNC_LOOKUP, '1, '0, '0);
    drain();

    for (ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 33 : (ph < 4) ? 67 : 0;
      recv_idle = (ph < 2) ? 67 : (ph < 4) ? 33 : 0;
      set_base(bases[ph]);
      load_random(counts[ph]);
      drain();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0 && walk_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
